@@ hdl/drgm_pkg.sv @@
// ----------------------------------------------------------------------------
// drgm_pkg: shared types and constants for the range-gated 3x3 mean filter
// Pixel and accumulator widths, config register codes, reciprocal table.
// ----------------------------------------------------------------------------
package drgm_pkg;

  localparam int PIX_W   = 16;   // depth sample width
  localparam int SUM_W   = 20;   // nine samples summed
  localparam int CNT_W   = 4;    // 1..9 contributors
  localparam int ROW_W   = 10;   // row counters
  localparam int DIM_W   = 11;   // width / height registers
  localparam int LIM_W   = 16;   // closeness limit
  localparam int CFG_W   = 16;   // config write data
  localparam int MIN_DIM = 3;
  localparam int H_MAX   = 1024;
  localparam int Q_DEPTH = 4;    // front-to-back queue, power of two

  localparam int RCP_SH  = SUM_W;
  localparam int RCP_W   = RCP_SH + 1;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [LIM_W-1:0] RST_LIMIT  = 16'd100;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_CLOSENESS
  } cfg_idx_t;

  // line store address bits: two rows plus window plus queue slack
  function automatic int addr_w(int max_width);
    return $clog2(2 * max_width + 4 + 2 * Q_DEPTH);
  endfunction

  // floor(2^RCP_SH / c)
  function automatic logic [RCP_W-1:0] recip(logic [CNT_W-1:0] c);
    logic [RCP_W-1:0] r;
    case (c)
      4'd1:    r = 21'd1048576;
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349525;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209715;
      4'd6:    r = 21'd174762;
      4'd7:    r = 21'd149796;
      4'd8:    r = 21'd131072;
      4'd9:    r = 21'd116508;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/drgm_queue.sv @@
// ----------------------------------------------------------------------------
// drgm_queue: small FIFO between front and back
// Holds emit descriptors so the input side keeps moving while the back works.
// ----------------------------------------------------------------------------
module drgm_queue import drgm_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int QA = $clog2(Q_DEPTH);
  localparam int QC = $clog2(Q_DEPTH + 1);

  logic [W-1:0]  slot_r [Q_DEPTH];
  logic [QA-1:0] wp_r, wp_nxt;
  logic [QA-1:0] rp_r, rp_nxt;
  logic [QC-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = cnt_r == QC'(Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slot_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

@@ hdl/drgm_front.sv @@
// ----------------------------------------------------------------------------
// drgm_front: input side of the filter
// Stores pixels into the line store, tracks input and output positions,
// and queues one emit descriptor (centre address, border, row/frame end)
// for every pixel that leaves the delay line.
// ----------------------------------------------------------------------------
module drgm_front import drgm_pkg::*; #(
  parameter  int MAX_WIDTH = 1024,
  localparam int AW        = addr_w(MAX_WIDTH),
  localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_depth,
  input  logic             in_flush,
  input  logic [WW-1:0]    width_eff,
  input  logic [DIM_W-1:0] height_eff,
  input  logic             q_full,
  output logic             q_push,
  output logic [AW+2:0]    q_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [PIX_W-1:0] wr_data
);

  localparam int RING = 2 * MAX_WIDTH + 4;
  localparam int PW   = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [AW-1:0] centre;
    logic          interior;
    logic          line_end;
    logic          frame_end;
  } ent_t;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    ocol_r, ocol_nxt;
  logic [ROW_W-1:0] orow_r, orow_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic [AW-1:0]    wptr_r, wptr_nxt;

  logic          acc, drain, emit, border, line_end;
  logic [PW-1:0] pend_w, pend_e, w_plus2;
  logic [AW-1:0] wptr_e;
  logic [WW-1:0] colp1, ocolp1;
  logic [DIM_W-1:0] rowp1, orowp1;
  ent_t          ent;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && !q_full;
  assign drain     = in_flush && col_r == '0 && row_r == '0;

  assign wr_en   = acc && !drain;
  assign wr_addr = wptr_r;
  assign wr_data = in_flush ? '0 : in_depth;

  assign w_plus2 = PW'(width_eff) + PW'(2);
  assign pend_w  = (pend_r < PW'(RING - 1)) ? pend_r + 1'b1 : pend_r;
  assign pend_e  = drain ? pend_r : pend_w;
  assign wptr_e  = drain ? wptr_r : wptr_r + 1'b1;
  assign emit    = acc && (drain ? pend_r != '0 : pend_w >= w_plus2);

  assign colp1  = WW'(col_r) + 1'b1;
  assign ocolp1 = WW'(ocol_r) + 1'b1;
  assign rowp1  = DIM_W'(row_r) + 1'b1;
  assign orowp1 = DIM_W'(orow_r) + 1'b1;

  assign line_end = WW'(ocol_r) == width_eff - 1'b1;
  assign border   = ocol_r == '0 || WW'(ocol_r) >= width_eff - 1'b1 ||
                    orow_r == '0 || DIM_W'(orow_r) >= height_eff - 1'b1 ||
                    pend_e < w_plus2;

  always_comb begin
    ent.centre    = wptr_e - AW'(pend_e);
    ent.interior  = !border;
    ent.line_end  = line_end;
    ent.frame_end = line_end && DIM_W'(orow_r) >= height_eff - 1'b1;
  end

  assign q_push = emit;
  assign q_data = ent;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    pend_nxt = pend_r;
    wptr_nxt = wptr_r;
    if (wr_en) begin
      wptr_nxt = wptr_e;
      pend_nxt = pend_w;
      if (colp1 >= width_eff) begin
        col_nxt = '0;
        row_nxt = (rowp1 >= height_eff) ? '0 : ROW_W'(rowp1);
      end else begin
        col_nxt = CW'(colp1);
      end
    end
    if (emit) begin
      pend_nxt = pend_e - 1'b1;
      if (ocolp1 >= width_eff) begin
        ocol_nxt = '0;
        orow_nxt = (orowp1 >= height_eff) ? '0 : ROW_W'(orowp1);
      end else begin
        ocol_nxt = CW'(ocolp1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      pend_r <= '0;
      wptr_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      pend_r <= pend_nxt;
      wptr_r <= wptr_nxt;
    end
  end

endmodule

@@ hdl/drgm_back.sv @@
// ----------------------------------------------------------------------------
// drgm_back: window fetch, gated accumulate, rounded divide, output register
// Owns the line store. Reads the centre and, for interior pixels, the eight
// neighbours one per cycle, then divides by a reciprocal multiply with a
// single correction step.
// ----------------------------------------------------------------------------
module drgm_back import drgm_pkg::*; #(
  parameter  int MAX_WIDTH = 1024,
  localparam int AW        = addr_w(MAX_WIDTH),
  localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic [WW-1:0]    width_eff,
  input  logic [LIM_W-1:0] limit,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [AW+2:0]    q_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_depth,
  output logic             out_line_end,
  output logic             out_frame_end
);

  localparam int DEPTH = 2 ** AW;
  localparam int PRD_W = SUM_W + RCP_W;
  localparam logic [CNT_W-1:0] NB_ALL = 4'd9;

  typedef struct packed {
    logic [AW-1:0] centre;
    logic          interior;
    logic          line_end;
    logic          frame_end;
  } ent_t;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_NORM, S_MUL, S_OUT} st_t;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  st_t              st_r, st_nxt;
  ent_t             ent_r, ent_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic [CNT_W-1:0] tag_r, tag_nxt;
  logic             dv_r, dv_nxt;
  logic [PIX_W-1:0] centre_r, centre_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] num_r, num_nxt;
  logic [PRD_W-1:0] prod_r, prod_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [PIX_W-1:0] out_depth_r, out_depth_nxt;
  logic             out_line_r, out_line_nxt;
  logic             out_frame_r, out_frame_nxt;

  logic [CNT_W-1:0] nreads;
  logic [PIX_W-1:0] diff;
  logic             take;
  logic [SUM_W-1:0] q0, rem, quo;

  function automatic logic [AW-1:0] nb_addr(logic [AW-1:0] c, logic [CNT_W-1:0] idx,
                                            logic [WW-1:0] w);
    logic [AW-1:0] wa;
    logic [AW-1:0] a;
    wa = AW'(w);
    unique case (idx)
      4'd1:    a = c - wa - 1'b1;
      4'd2:    a = c - wa;
      4'd3:    a = c - wa + 1'b1;
      4'd4:    a = c - 1'b1;
      4'd5:    a = c + 1'b1;
      4'd6:    a = c + wa - 1'b1;
      4'd7:    a = c + wa;
      4'd8:    a = c + wa + 1'b1;
      default: a = c;
    endcase
    return a;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign nreads = ent_r.interior ? NB_ALL : CNT_W'(1);
  assign diff   = (rd_data_r > centre_r) ? rd_data_r - centre_r : centre_r - rd_data_r;
  assign take   = centre_r != '0 && rd_data_r != '0 && diff < limit;

  assign q0  = SUM_W'(prod_r >> RCP_SH);
  assign rem = num_r - SUM_W'(q0 * cnt_r);
  assign quo = (rem >= SUM_W'(cnt_r)) ? q0 + 1'b1 : q0;

  always_comb begin
    st_nxt         = st_r;
    ent_nxt        = ent_r;
    iss_nxt        = iss_r;
    tag_nxt        = tag_r;
    dv_nxt         = dv_r;
    centre_nxt     = centre_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    num_nxt        = num_r;
    prod_nxt       = prod_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_depth_nxt  = out_depth_r;
    out_line_nxt   = out_line_r;
    out_frame_nxt  = out_frame_r;
    rd_en          = 1'b0;
    rd_addr        = ent_r.centre;
    q_pop          = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = ent_t'(q_data);
          rd_en   = 1'b1;
          rd_addr = ent_nxt.centre;
          iss_nxt = CNT_W'(1);
          tag_nxt = '0;
          dv_nxt  = 1'b1;
          st_nxt  = S_READ;
        end
      end
      S_READ: begin
        if (dv_r) begin
          if (tag_r == '0) begin
            centre_nxt = rd_data_r;
            sum_nxt    = SUM_W'(rd_data_r);
            cnt_nxt    = CNT_W'(1);
          end else if (take) begin
            sum_nxt = sum_r + SUM_W'(rd_data_r);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (iss_r < nreads) begin
          rd_en   = 1'b1;
          rd_addr = nb_addr(ent_r.centre, iss_r, width_eff);
          iss_nxt = iss_r + 1'b1;
          tag_nxt = iss_r;
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r && tag_r == nreads - 1'b1) begin
          st_nxt = S_NORM;
        end
      end
      S_NORM: begin
        num_nxt = sum_r + SUM_W'(cnt_r >> 1);
        st_nxt  = S_MUL;
      end
      S_MUL: begin
        prod_nxt = PRD_W'(num_r) * PRD_W'(recip(cnt_r));
        st_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_depth_nxt  = quo[PIX_W-1:0];
          out_line_nxt   = ent_r.line_end;
          out_frame_nxt  = ent_r.frame_end;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      dv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      dv_r         <= dv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ent_r       <= ent_nxt;
    iss_r       <= iss_nxt;
    tag_r       <= tag_nxt;
    centre_r    <= centre_nxt;
    sum_r       <= sum_nxt;
    cnt_r       <= cnt_nxt;
    num_r       <= num_nxt;
    prod_r      <= prod_nxt;
    out_depth_r <= out_depth_nxt;
    out_line_r  <= out_line_nxt;
    out_frame_r <= out_frame_nxt;
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_depth     = out_depth_r;
  assign out_line_end  = out_line_r;
  assign out_frame_end = out_frame_r;

endmodule

@@ hdl/depth_range_gated_mean_3x3.sv @@
// ----------------------------------------------------------------------------
// depth_range_gated_mean_3x3: range-gated 3x3 mean filter for depth streams
// Raster-order depth pixels in, filtered pixels out, one row plus one pixel
// behind; flush items drain the tail.
// ----------------------------------------------------------------------------
// An input item is taken whenever the four-entry descriptor queue has
// room. The back end works on one descriptor at a time and finishes its
// result before it pops the next: the line store has a single read port,
// so the centre and, for an interior pixel, its eight neighbours are
// fetched one per cycle, followed by a normalize, reciprocal-multiply and
// correction step. Bursts of up to four results are absorbed by the queue.
// The line store holds 2^ceil(log2(2*MAX_WIDTH+12)) pixels and needs no
// clearing after reset. Width is clamped to [3, MAX_WIDTH], height to
// [3, 1024]; the user must write configuration only while the block is
// idle, and the block itself does not enforce this.

module depth_range_gated_mean_3x3 import drgm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,    // [15:0] depth_mm
  input  logic             in_tuser,    // [0] flush
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,   // [15:0] filtered_depth
  output logic             out_tlast,   // line_end
  output logic             out_tuser,   // [0] frame_end
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW    = addr_w(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int ENT_W = AW + 3;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [LIM_W-1:0] limit_r, limit_nxt;
  logic [WW-1:0]    width_eff;
  logic [DIM_W-1:0] height_eff;

  logic             q_full, q_empty, q_push, q_pop;
  logic [ENT_W-1:0] q_wdata, q_rdata;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    limit_nxt  = limit_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata[DIM_W-1:0];
        CFG_CLOSENESS:    limit_nxt  = cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      limit_r  <= RST_LIMIT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      limit_r  <= limit_nxt;
    end
  end

  always_comb begin
    if (width_r < DIM_W'(MIN_DIM)) begin
      width_eff = WW'(MIN_DIM);
    end else if (32'(width_r) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_r);
    end
    if (height_r < DIM_W'(MIN_DIM)) begin
      height_eff = DIM_W'(MIN_DIM);
    end else if (height_r > DIM_W'(H_MAX)) begin
      height_eff = DIM_W'(H_MAX);
    end else begin
      height_eff = height_r;
    end
  end

  drgm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_depth   (in_tdata[PIX_W-1:0]),
    .in_flush   (in_tuser),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  drgm_queue #(
    .W (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  drgm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .width_eff     (width_eff),
    .limit         (limit_r),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_depth     (out_tdata),
    .out_line_end  (out_tlast),
    .out_frame_end (out_tuser)
  );

endmodule
